/* hw/rtl/fwalu_pkg.sv */
// shared types and constants for the fixed-width integer alu
package fwalu_pkg;

    // widths of the word fields
    localparam int OP_W   = 3;
    localparam int DATA_W = 64;

    // default operand size in bytes
    localparam int DEF_OPERAND_BYTES = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_MOD = 3'd4;

    // one step of the shared datapath
    typedef enum logic [3:0] {
        DP_HOLD,
        DP_LOAD,
        DP_ADD,
        DP_SUB,
        DP_ABS_A,
        DP_ABS_B,
        DP_MUL_STEP,
        DP_DIV_STEP,
        DP_FIX_Q,
        DP_FIX_R
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_ctrl;

endpackage

/* hw/rtl/fwalu_datapath.sv */
// operand registers around one shared adder for add, sub, shift-add multiply and division
module fwalu_datapath import fwalu_pkg::*; #(
    parameter int W = DATA_W
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  t_dp_ctrl     i_ctrl,
    output logic [W-1:0] o_acc,
    output logic [W-1:0] o_q,
    output logic         o_carry
);

    logic [W-1:0] r_a, n_a;
    logic [W-1:0] r_b, n_b;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_q, n_q;
    logic         r_carry, n_carry;
    logic         r_a_neg, n_a_neg;
    logic         r_b_neg, n_b_neg;

    // the one shared adder
    logic [W:0]   add_x;
    logic [W:0]   add_y;
    logic         add_cin;
    logic [W+1:0] add_sum;

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + (W+2)'(add_cin);

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_q     = r_q;
        n_carry = r_carry;
        n_a_neg = r_a_neg;
        n_b_neg = r_b_neg;
        case (i_ctrl.op)
            DP_LOAD: begin
                n_a     = i_a;
                n_b     = i_b;
                n_q     = i_a;
                n_acc   = '0;
                n_carry = 1'b0;
                n_a_neg = i_a[W-1];
                n_b_neg = i_b[W-1];
            end
            DP_ADD: begin
                add_x   = {1'b0, r_a};
                add_y   = {1'b0, r_b};
                n_acc   = add_sum[W-1:0];
                n_carry = add_sum[W];
            end
            DP_SUB: begin
                // a + ~b + 1; negating zero gives zero, so no carry then
                add_x   = {1'b0, r_a};
                add_y   = {1'b0, ~r_b};
                add_cin = 1'b1;
                n_acc   = add_sum[W-1:0];
                n_carry = add_sum[W] & (|r_b);
            end
            DP_ABS_A: begin
                add_y   = {1'b0, ~r_a};
                add_cin = 1'b1;
                if (r_a_neg) begin
                    n_q = add_sum[W-1:0];
                end
            end
            DP_ABS_B: begin
                add_y   = {1'b0, ~r_b};
                add_cin = 1'b1;
                if (r_b_neg) begin
                    n_b = add_sum[W-1:0];
                end
            end
            DP_MUL_STEP: begin
                add_x = {1'b0, r_acc};
                add_y = r_b[0] ? {1'b0, r_a} : '0;
                n_acc = add_sum[W-1:0];
                n_a   = r_a << 1;
                n_b   = r_b >> 1;
            end
            DP_DIV_STEP: begin
                // trial subtract of the divisor from the shifted remainder
                add_x   = {r_acc, r_q[W-1]};
                add_y   = ~{1'b0, r_b};
                add_cin = 1'b1;
                if (add_sum[W+1]) begin
                    n_acc = add_sum[W-1:0];
                end else begin
                    n_acc = {r_acc[W-2:0], r_q[W-1]};
                end
                n_q = {r_q[W-2:0], add_sum[W+1]};
            end
            DP_FIX_Q: begin
                add_y   = {1'b0, ~r_q};
                add_cin = 1'b1;
                if (r_a_neg ^ r_b_neg) begin
                    n_q = add_sum[W-1:0];
                end
            end
            DP_FIX_R: begin
                // remainder takes the sign of the dividend
                add_y   = {1'b0, ~r_acc};
                add_cin = 1'b1;
                if (r_a_neg) begin
                    n_acc = add_sum[W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_q     <= n_q;
        r_carry <= n_carry;
        r_a_neg <= n_a_neg;
        r_b_neg <= n_b_neg;
    end

    assign o_acc          = r_acc;
    assign o_q            = r_q;
    assign o_carry        = r_carry;

endmodule

/* hw/rtl/fixed_width_integer_alu_unit.sv */
// top level of the fixed-width integer alu: sequencer, handshake and output register
// Fixed-width integer ALU. Each input word carries an op code and two two's-complement
// operands of OPERAND_BYTES bytes (W = 8 * OPERAND_BYTES bits, only the low W bits are
// used); each gives exactly one output word with the W-bit wrapped result sign-extended
// to 64 bits, the carry out of the top bit for add and subtract, and a divide-by-zero
// flag. Divide truncates toward zero, modulo keeps the sign of the dividend, and a zero
// divisor gives result 0 with the flag set; unused op codes give all zeros. All work
// runs through one shared W+1 bit adder under a small sequencer, and the block takes
// no new word until the current one is in the output register. Add and subtract take
// one adder step, multiply one shift-add step per multiplier bit, divide and modulo
// two magnitude steps, one restoring step per dividend bit and one sign fix, and unused
// codes and divide or modulo by zero skip the arithmetic. The output register frees the
// input side: a finished result may wait on i_out_stall while the next word is already
// accepted and computed.
module fixed_width_integer_alu_unit import fwalu_pkg::*; #(
    parameter int OPERAND_BYTES = DEF_OPERAND_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_result_value,
    output logic              o_carry_out,
    output logic              o_divide_by_zero
);

    localparam int W     = 8 * OPERAND_BYTES;
    localparam int CNT_W = $clog2(W);

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ADDSUB = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_ABS_A  = 8'b0000_1000,
        S_ABS_B  = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_FIX    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic              r_dz, n_dz;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_result, n_result;
    logic              r_carry, n_carry;
    logic              r_dz_out, n_dz_out;

    logic              in_accept;
    logic              out_free;
    logic              cnt_last;
    logic              b_zero;
    logic [W-1:0]      res_w;
    logic              res_carry;

    t_dp_ctrl          dp_ctrl;
    logic [W-1:0]      dp_acc;
    logic [W-1:0]      dp_q;
    logic              dp_carry;

    fwalu_datapath #(
        .W (W)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_a      (i_operand_a[W-1:0]),
        .i_b      (i_operand_b[W-1:0]),
        .i_ctrl   (dp_ctrl),
        .o_acc    (dp_acc),
        .o_q      (dp_q),
        .o_carry  (dp_carry)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    // output register can take a word when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cnt_last   = (r_cnt == CNT_W'(W - 1));
    assign b_zero     = (i_operand_b[W-1:0] == '0);

    // pick the finished result out of the datapath registers
    always_comb begin
        res_w     = '0;
        res_carry = 1'b0;
        case (r_op)
            OP_ADD, OP_SUB: begin
                res_w     = dp_acc;
                res_carry = dp_carry;
            end
            OP_MUL: begin
                res_w = dp_acc;
            end
            OP_DIV: begin
                res_w = r_dz ? '0 : dp_q;
            end
            OP_MOD: begin
                res_w = r_dz ? '0 : dp_acc;
            end
            default: begin
                res_w = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_dz        = r_dz;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_result    = r_result;
        n_carry     = r_carry;
        n_dz_out    = r_dz_out;
        dp_ctrl.op  = DP_HOLD;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    dp_ctrl.op = DP_LOAD;
                    n_op       = i_op;
                    n_dz       = (i_op inside {OP_DIV, OP_MOD}) && b_zero;
                    n_cnt      = '0;
                    case (i_op)
                        OP_ADD, OP_SUB: n_state = S_ADDSUB;
                        OP_MUL:         n_state = S_MUL;
                        OP_DIV, OP_MOD: n_state = b_zero ? S_DONE : S_ABS_A;
                        default:        n_state = S_DONE;
                    endcase
                end
            end
            S_ADDSUB: begin
                dp_ctrl.op = (r_op == OP_SUB) ? DP_SUB : DP_ADD;
                n_state    = S_DONE;
            end
            S_MUL: begin
                // one multiplier bit per cycle
                dp_ctrl.op = DP_MUL_STEP;
                n_cnt      = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_ABS_A: begin
                dp_ctrl.op = DP_ABS_A;
                n_state    = S_ABS_B;
            end
            S_ABS_B: begin
                dp_ctrl.op = DP_ABS_B;
                n_state    = S_DIV;
            end
            S_DIV: begin
                // one quotient bit per cycle, msb first
                dp_ctrl.op = DP_DIV_STEP;
                n_cnt      = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // sign of the quotient or remainder
                dp_ctrl.op = (r_op == OP_DIV) ? DP_FIX_Q : DP_FIX_R;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_result    = DATA_W'(signed'(res_w));
                    n_carry     = res_carry;
                    n_dz_out    = r_dz;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_dz     <= n_dz;
        r_cnt    <= n_cnt;
        r_result <= n_result;
        r_carry  <= n_carry;
        r_dz_out <= n_dz_out;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_value   = r_result;
    assign o_carry_out      = r_carry;
    assign o_divide_by_zero = r_dz_out;

endmodule

/* test/fixed_width_integer_alu_unit_tb.sv */
// self-checking testbench for the fixed-width integer alu unit
module testbench;
    import fwalu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // operand size under test and the masks that follow from it
    localparam int ALU_BYTES = DEF_OPERAND_BYTES;
    localparam int WIDTH = 8 * ALU_BYTES;
    localparam logic [DATA_W-1:0] WIDTH_MASK = {DATA_W{1'b1}} >> (DATA_W - WIDTH);
    // most positive and most negative values, sign-extended to the port width
    localparam logic [DATA_W-1:0] MOST_POS = WIDTH_MASK >> 1;
    localparam logic [DATA_W-1:0] MOST_NEG = ~MOST_POS;
    localparam logic [DATA_W-1:0] MINUS_ONE = {DATA_W{1'b1}};

    // op codes the block does not define, they must give an all-zero word
    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_MOD + 1'b1;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = {OP_W{1'b1}};

    // tail wait, long enough to cover the slowest op with margin
    localparam int TAIL_CYCLES = WIDTH + 40;
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 520;
    localparam longint TIMEOUT_NS = 40_000_000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              carry;
        logic              div_zero;
    } t_alu_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_op = OP_ADD;
    logic [DATA_W-1:0] i_operand_a = '0;
    logic [DATA_W-1:0] i_operand_b = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [DATA_W-1:0] o_result_value;
    logic              o_carry_out;
    logic              o_divide_by_zero;

    // expected output words, oldest first
    t_alu_word pending_alu_words[$];
    int        mismatch_count = 0;

    // idle rates in percent per cycle, changed by the test phases
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    // cycles left in a forced output hold-off
    int        hold_off_left = 0;

    fixed_width_integer_alu_unit #(
        .OPERAND_BYTES(ALU_BYTES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_value   (o_result_value),
        .o_carry_out      (o_carry_out),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted output word for one input word, all arithmetic on W-bit values
    function automatic t_alu_word compute_alu_word(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] a_in,
                                                   input logic [DATA_W-1:0] b_in);
        logic [DATA_W-1:0] a, b, a_mag, b_mag, quo, res;
        logic [DATA_W:0]   sum;
        t_alu_word         w;
        a = a_in & WIDTH_MASK;
        b = b_in & WIDTH_MASK;
        res = '0;
        w = '0;
        case (op)
            OP_ADD: begin
                sum = {1'b0, a} + {1'b0, b};
                res = sum[DATA_W-1:0] & WIDTH_MASK;
                w.carry = sum[WIDTH];
            end
            OP_SUB: begin
                // subtract adds the negated subtrahend, so minus zero gives no carry
                sum = {1'b0, a} + {1'b0, (-b) & WIDTH_MASK};
                res = sum[DATA_W-1:0] & WIDTH_MASK;
                w.carry = sum[WIDTH];
            end
            OP_MUL: begin
                res = (a * b) & WIDTH_MASK;
            end
            OP_DIV, OP_MOD: begin
                if (b == '0) begin
                    w.div_zero = 1'b1;
                end else begin
                    // magnitudes are unsigned, so the most negative value keeps 2^(W-1)
                    a_mag = a[WIDTH-1] ? ((-a) & WIDTH_MASK) : a;
                    b_mag = b[WIDTH-1] ? ((-b) & WIDTH_MASK) : b;
                    quo = a_mag / b_mag;
                    if (a[WIDTH-1] != b[WIDTH-1]) begin
                        quo = -quo;
                    end
                    quo = quo & WIDTH_MASK;
                    if (op == OP_DIV) begin
                        res = quo;
                    end else begin
                        res = (a - ((b * quo) & WIDTH_MASK)) & WIDTH_MASK;
                    end
                end
            end
            default: begin
            end
        endcase
        w.value = res[WIDTH-1] ? (res | ~WIDTH_MASK) : res;
        return w;
    endfunction

    // mostly defined ops, now and then an unused code
    function automatic logic [OP_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 15) begin
            return OP_W'(r % 5);
        end
        return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    // operand shapes chosen so division sees a wide spread of quotients
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
            end
            4, 5: begin
                // random magnitude: arithmetic shift keeps the sign
                v = $signed(v) >>> $urandom_range(1, DATA_W - 1);
            end
            6, 7: begin
                v = DATA_W'($urandom_range(0, 40));
                if ($urandom_range(0, 1)) v = -v;
            end
            8: begin
                v = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = MINUS_ONE;
                    3: v = '0;
                    default: v = DATA_W'(1);
                endcase
            end
        endcase
        return v;
    endfunction

    // offer one word, with random idle cycles first; returns at the accepting edge
    // and leaves valid high so the next word can follow without a gap
    task automatic send_alu_word(input logic [OP_W-1:0] op,
                                 input logic [DATA_W-1:0] a,
                                 input logic [DATA_W-1:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_alu_words.push_back(compute_alu_word(op, a, b));
    endtask

    // drop valid before any wait outside send_alu_word
    task automatic release_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_until_drained();
        int waited;
        waited = 0;
        while (pending_alu_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // corner words: wrap and carry on add and subtract, product overflow,
    // divide by zero, most negative dividend by minus one, truncation signs
    task automatic test_directed_corners();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_alu_word(OP_ADD, MOST_POS, DATA_W'(1));
        send_alu_word(OP_ADD, MINUS_ONE, DATA_W'(1));
        send_alu_word(OP_ADD, MOST_NEG, MOST_NEG);
        send_alu_word(OP_ADD, '0, '0);
        send_alu_word(OP_SUB, DATA_W'(5), '0);
        send_alu_word(OP_SUB, '0, DATA_W'(1));
        send_alu_word(OP_SUB, MOST_NEG, DATA_W'(1));
        send_alu_word(OP_SUB, MINUS_ONE, MINUS_ONE);
        send_alu_word(OP_MUL, MOST_POS, MOST_POS);
        send_alu_word(OP_MUL, MOST_NEG, MINUS_ONE);
        send_alu_word(OP_MUL, DATA_W'(123), '0);
        send_alu_word(OP_MUL, MINUS_ONE, MINUS_ONE);
        send_alu_word(OP_DIV, DATA_W'(7), '0);
        send_alu_word(OP_MOD, MOST_NEG, '0);
        send_alu_word(OP_DIV, MOST_NEG, MINUS_ONE);
        send_alu_word(OP_MOD, MOST_NEG, MINUS_ONE);
        send_alu_word(OP_DIV, -DATA_W'(7), DATA_W'(2));
        send_alu_word(OP_MOD, -DATA_W'(7), DATA_W'(2));
        send_alu_word(OP_DIV, DATA_W'(7), -DATA_W'(2));
        send_alu_word(OP_MOD, MOST_POS, MOST_NEG);
        send_alu_word(OP_DIV, MOST_NEG, MOST_NEG);
        for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++) begin
            send_alu_word(OP_W'(c), pick_operand(), pick_operand());
        end
    endtask

    // random words under one pair of idle rates
    task automatic test_random_mix(input int send_idle, input int recv_stall,
                                   input int count);
        sender_idle_pct = send_idle;
        receiver_stall_pct = recv_stall;
        repeat (count) begin
            send_alu_word(pick_op(), pick_operand(), pick_operand());
        end
    endtask

    // long output hold-off while words keep coming: the result register fills
    // and the block has to stall its input
    task automatic test_output_hold_off();
        sender_idle_pct = 0;
        receiver_stall_pct = 20;
        hold_off_left <= HOLD_OFF_CYCLES;
        repeat (12) begin
            send_alu_word(pick_op(), pick_operand(), pick_operand());
        end
    endtask

    // short bursts, each followed by a pause until every result is back
    task automatic test_drain_pauses();
        sender_idle_pct = 20;
        receiver_stall_pct = 30;
        repeat (30) begin
            repeat ($urandom_range(1, 8)) begin
                send_alu_word(pick_op(), pick_operand(), pick_operand());
            end
            release_input();
            wait_until_drained();
        end
    endtask

    // receiver: random stall, or a forced hold-off counted down here
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // each accepted output word against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_alu_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_alu_words.size() == 0) begin
                $error("output word with nothing expected: value %h", o_result_value);
                mismatch_count++;
            end else begin
                want = pending_alu_words.pop_front();
                if (o_result_value !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value, o_result_value);
                    mismatch_count++;
                end
                if (o_carry_out !== want.carry) begin
                    $error("carry_out: expected %b, got %b", want.carry, o_carry_out);
                    mismatch_count++;
                end
                if (o_divide_by_zero !== want.div_zero) begin
                    $error("divide_by_zero: expected %b, got %b", want.div_zero,
                           o_divide_by_zero);
                    mismatch_count++;
                end
            end
        end
    end

    // hard limit in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("fixed_width_integer_alu_unit: mismatch");
        $finish;
    end

    initial begin
        // synchronous reset, released once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        // receiver stalls more in the first phase, sender idles more in the second, none in the third
        test_random_mix(36, 71, RANDOM_PER_PHASE);
        test_random_mix(71, 36, RANDOM_PER_PHASE);
        test_random_mix(0, 0, RANDOM_PER_PHASE);
        test_output_hold_off();
        test_drain_pauses();

        // let everything come back, then a tail to catch stray words
        release_input();
        receiver_stall_pct = 0;
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_alu_words.size() != 0) begin
            $error("%0d expected words never came out", pending_alu_words.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("fixed_width_integer_alu_unit: match");
        end else begin
            $display("fixed_width_integer_alu_unit: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fwalu_pkg.sv
hw/rtl/fwalu_datapath.sv
hw/rtl/fixed_width_integer_alu_unit.sv
test/fixed_width_integer_alu_unit_tb.sv
